/* hw/rtl/plbc_pkg.sv */
// Shared constants, codes and control/status types of the block cache controller.
`timescale 1ns / 1ps
`default_nettype none
package plbc_pkg;

   // Fixed field widths of the command and result words.
   localparam int DEV_W  = 4;
   localparam int LBA_W  = 48;
   localparam int SECT_W = 49;

   // Default geometry.
   localparam int ENTRIES_DEF  = 16;
   localparam int PIN_BITS_DEF = 8;
   localparam int AGE_BITS_DEF = 16;

   // Command codes.
   localparam logic [2:0] CMD_ACQUIRE    = 3'd0;
   localparam logic [2:0] CMD_MARK_DIRTY = 3'd1;
   localparam logic [2:0] CMD_RELEASE    = 3'd2;
   localparam logic [2:0] CMD_FLUSH      = 3'd3;
   localparam logic [2:0] CMD_INVALIDATE = 3'd4;
   localparam logic [2:0] CMD_QUERY      = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   // Status codes.
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_PIN_OVERFLOW = 4'd1;
   localparam logic [3:0] ST_ALL_PINNED   = 4'd2;
   localparam logic [3:0] ST_BAD_SIZE     = 4'd3;
   localparam logic [3:0] ST_OUT_OF_RANGE = 4'd4;
   localparam logic [3:0] ST_READ_FAILED  = 4'd5;
   localparam logic [3:0] ST_WB_FAILED    = 4'd6;
   localparam logic [3:0] ST_MISMATCH     = 4'd7;
   localparam logic [3:0] ST_PIN_UNDER    = 4'd8;
   localparam logic [3:0] ST_PINNED_DIRTY = 4'd9;
   localparam logic [3:0] ST_DEV_FLUSH    = 4'd10;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS    = 2'd0;
   localparam logic [1:0] KIND_WRITEBACK = 2'd1;
   localparam logic [1:0] KIND_FILL      = 2'd2;
   localparam logic [1:0] KIND_DEV_FLUSH = 2'd3;

   // Flush phases.
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_WRITING  = 3'd1;
   localparam logic [2:0] PH_FLUSHING = 3'd2;
   localparam logic [2:0] PH_COMPLETE = 3'd3;
   localparam logic [2:0] PH_FAILED   = 3'd4;

   // Device status codes that matter.
   localparam logic [2:0] DS_READ_ONLY  = 3'd1;
   localparam logic [2:0] DS_WRONG_SIZE = 3'd4;

   // Entry modes (invalid is held in the valid bits).
   localparam logic [1:0] MODE_CLEAN  = 2'd1;
   localparam logic [1:0] MODE_DIRTY  = 2'd2;
   localparam logic [1:0] MODE_WBFAIL = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_INIT,
      OP_LOOKUP,
      OP_FCHK,
      OP_FWB,
      OP_ICHK,
      OP_ICLR,
      OP_QUERY,
      OP_RENUM,
      OP_NA_LOAD,
      OP_INC_PIN,
      OP_VIC_TGT,
      OP_EMIT_VWB,
      OP_EMIT_FILL,
      OP_RD_TGT,
      OP_WR_AGE,
      OP_RD_IDX,
      OP_MARK,
      OP_REL,
      OP_EMIT_DFL,
      OP_CLEAR,
      OP_EMIT_ST
   } op_type;

   // Command from controller to datapath.
   typedef struct packed {
      op_type     op;
      logic       set_st;
      logic [3:0] st;
      logic       set_prog;
      logic [2:0] prog;
      logic       clr_err;
   } ctl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       stop;
      logic       last;
      logic       e_pinned;
      logic       tgt_pins_max;
      logic       vic_any;
      logic       vic_dirty;
      logic       bad_size;
      logic       oor;
      logic       not_ready;
      logic       age_wrap;
      logic       idx_ok;
      logic       rd_pins_zero;
      logic       wok;
      logic       rok;
      logic       fok;
   } dp_sts_type;

endpackage
`default_nettype wire

/* hw/rtl/plbc_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module plbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* hw/rtl/plbc_dp.sv */
// Datapath: entry store, valid bits, scan engine, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module plbc_dp import plbc_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int PIN_BITS = PIN_BITS_DEF,
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       cmd,
   output dp_sts_type             sts,
   input  wire logic [2:0]        req_cmd,
   input  wire logic [DEV_W-1:0]  req_device_id,
   input  wire logic [LBA_W-1:0]  req_lba,
   input  wire logic [3:0]        req_entry_index,
   input  wire logic [2:0]        req_device_status,
   input  wire logic [SECT_W-1:0] req_device_sectors,
   input  wire logic              req_write_ok,
   input  wire logic              req_read_ok,
   input  wire logic              req_flush_ok,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_kind,
   output logic [3:0]             rsp_status,
   output logic [3:0]             rsp_slot,
   output logic [DEV_W-1:0]       rsp_req_device,
   output logic [LBA_W-1:0]       rsp_req_lba,
   output logic [4:0]             rsp_valid_count,
   output logic [4:0]             rsp_dirty_count,
   output logic [4:0]             rsp_pinned_count,
   output logic [2:0]             rsp_flush_phase,
   output logic [3:0]             rsp_recorded_error,
   output logic                   rsp_last
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int AGE_LO  = 0;
   localparam int PIN_LO  = AGE_LO + AGE_BITS;
   localparam int SEC_LO  = PIN_LO + PIN_BITS;
   localparam int DEV_LO  = SEC_LO + LBA_W;
   localparam int MODE_LO = DEV_LO + DEV_W;
   localparam int WORD_W  = MODE_LO + 2;

   // Latched command word.
   logic [2:0]          cmd_ff, cmd_in;
   logic [DEV_W-1:0]    dev_ff, dev_in;
   logic [LBA_W-1:0]    lba_ff, lba_in;
   logic [3:0]          eidx_ff, eidx_in;
   logic [2:0]          dstat_ff, dstat_in;
   logic [SECT_W-1:0]   sect_ff, sect_in;
   logic                wok_ff, wok_in, rok_ff, rok_in, fok_ff, fok_in;

   // Cache state.
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [AGE_BITS-1:0] next_age_ff, next_age_in;
   logic [2:0]          prog_ff, prog_in;
   logic [3:0]          err_ff, err_in;

   // Scan engine and working registers.
   logic [IDX_W:0]      addr_ff, addr_in;
   logic                pv_ff, pv_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;
   logic [IDX_W-1:0]    tgt_ff, tgt_in;
   logic [WORD_W-1:0]   tgt_word_ff, tgt_word_in;
   logic                found_ff, found_in;
   logic                inv_found_ff, inv_found_in;
   logic                vic_ok_ff, vic_ok_in;
   logic [IDX_W-1:0]    vic_ff, vic_in;
   logic [WORD_W-1:0]   vic_word_ff, vic_word_in;
   logic [AGE_BITS-1:0] a_ff, a_in;
   logic [3:0]          st_ff, st_in;
   logic [3:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]    vcnt_ff, vcnt_in, dcnt_ff, dcnt_in, pcnt_ff, pcnt_in;

   // Result register.
   logic                strobe_ff, strobe_in;
   logic [1:0]          kind_ff, kind_in;
   logic [3:0]          ost_ff, ost_in;
   logic [3:0]          oslot_ff, oslot_in;
   logic [DEV_W-1:0]    odev_ff, odev_in;
   logic [LBA_W-1:0]    olba_ff, olba_in;
   logic [4:0]          ov_ff, ov_in, od_ff, od_in, op_ff, op_in;
   logic [2:0]          oph_ff, oph_in;
   logic [3:0]          oerr_ff, oerr_in;
   logic                olast_ff, olast_in;

   // Store ports.
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [WORD_W-1:0]   wr_data, rd_word;

   // Fields of the entry under evaluation.
   logic                e_v, e_dirty, e_pinned, e_match, e_hit, ev, scanning;
   logic [1:0]          e_mode;
   logic [DEV_W-1:0]    e_dev;
   logic [LBA_W-1:0]    e_sec;
   logic [PIN_BITS-1:0] e_pins, tgt_pins;
   logic [AGE_BITS-1:0] e_age, vic_age;
   logic [IDX_W-1:0]    eidx_ext;
   logic [3:0]          err_out;
   logic [WORD_W-1:0]   fill_word;

   plbc_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Decode the word read back from the store.
   always_comb begin
      e_v      = valid_ff[ridx_ff];
      e_mode   = rd_word[MODE_LO +: 2];
      e_dev    = rd_word[DEV_LO +: DEV_W];
      e_sec    = rd_word[SEC_LO +: LBA_W];
      e_pins   = rd_word[PIN_LO +: PIN_BITS];
      e_age    = rd_word[AGE_LO +: AGE_BITS];
      e_dirty  = e_v && e_mode[1];
      e_pinned = e_v && (e_pins != '0);
      e_match  = e_v && (e_dev == dev_ff);
      e_hit    = e_match && (e_sec == lba_ff);
      ev       = pv_ff;
      tgt_pins = tgt_word_ff[PIN_LO +: PIN_BITS];
      vic_age  = vic_word_ff[AGE_LO +: AGE_BITS];
      eidx_ext = IDX_W'(eidx_ff);
      err_out  = (st_ff != ST_OK) ? st_ff : err_ff;
      scanning = cmd.op inside {OP_LOOKUP, OP_FCHK, OP_FWB, OP_ICHK, OP_ICLR,
                                OP_QUERY, OP_RENUM};
      fill_word = '0;
      fill_word[MODE_LO +: 2]       = MODE_CLEAN;
      fill_word[DEV_LO +: DEV_W]    = dev_ff;
      fill_word[SEC_LO +: LBA_W]    = lba_ff;
      fill_word[PIN_LO +: PIN_BITS] = PIN_BITS'(1);
   end

   // Status back to the controller.
   always_comb begin
      sts.cmd          = cmd_ff;
      sts.last         = pv_ff && (ridx_ff == IDX_W'(ENTRIES - 1));
      sts.e_pinned     = e_pinned;
      sts.tgt_pins_max = &tgt_pins;
      sts.vic_any      = inv_found_ff || vic_ok_ff;
      sts.vic_dirty    = !inv_found_ff && vic_word_ff[MODE_LO + 1];
      sts.bad_size     = dstat_ff == DS_WRONG_SIZE;
      sts.oor          = {1'b0, lba_ff} >= sect_ff;
      sts.not_ready    = dstat_ff > DS_READ_ONLY;
      sts.age_wrap     = &next_age_ff;
      sts.idx_ok       = (32'(eidx_ff) < ENTRIES) && valid_ff[eidx_ext];
      sts.rd_pins_zero = e_pins == '0;
      sts.wok          = wok_ff;
      sts.rok          = rok_ff;
      sts.fok          = fok_ff;
      case (cmd.op)
         OP_LOOKUP: sts.stop = ev && e_hit;
         OP_FCHK:   sts.stop = ev && e_match && e_pinned && e_dirty;
         OP_FWB:    sts.stop = ev && e_match && e_dirty && !wok_ff;
         OP_ICHK:   sts.stop = ev && e_match && (e_pinned || e_dirty);
         default:   sts.stop = 1'b0;
      endcase
   end

   // Next-state logic for each operation.
   always_comb begin
      cmd_in = cmd_ff; dev_in = dev_ff; lba_in = lba_ff; eidx_in = eidx_ff;
      dstat_in = dstat_ff; sect_in = sect_ff;
      wok_in = wok_ff; rok_in = rok_ff; fok_in = fok_ff;
      valid_in = valid_ff; next_age_in = next_age_ff; prog_in = prog_ff; err_in = err_ff;
      addr_in = addr_ff; ridx_in = addr_ff[IDX_W-1:0];
      pv_in = scanning && (addr_ff < (IDX_W + 1)'(ENTRIES));
      tgt_in = tgt_ff; tgt_word_in = tgt_word_ff; found_in = found_ff;
      inv_found_in = inv_found_ff; vic_ok_in = vic_ok_ff; vic_in = vic_ff;
      vic_word_in = vic_word_ff; a_in = a_ff; st_in = st_ff; slot_in = slot_ff;
      vcnt_in = vcnt_ff; dcnt_in = dcnt_ff; pcnt_in = pcnt_ff;
      strobe_in = 1'b0; kind_in = KIND_STATUS; ost_in = ST_OK; oslot_in = '0;
      odev_in = '0; olba_in = '0; ov_in = '0; od_in = '0; op_in = '0;
      oph_in = PH_IDLE; oerr_in = '0; olast_in = 1'b0;
      wr_en = 1'b0; wr_addr = ridx_ff; wr_data = rd_word;
      rd_addr = addr_ff[IDX_W-1:0];

      if (scanning && pv_in) begin
         addr_in = addr_ff + (IDX_W + 1)'(1);
      end

      case (cmd.op)
         OP_LOAD: begin
            cmd_in = req_cmd; dev_in = req_device_id; lba_in = req_lba;
            eidx_in = req_entry_index; dstat_in = req_device_status;
            sect_in = req_device_sectors; wok_in = req_write_ok;
            rok_in = req_read_ok; fok_in = req_flush_ok;
            st_in = ST_OK;
            slot_in = (req_cmd == CMD_MARK_DIRTY || req_cmd == CMD_RELEASE) ?
                      req_entry_index : 4'd0;
            vcnt_in = '0; dcnt_in = '0; pcnt_in = '0;
         end
         OP_SCAN_INIT: begin
            addr_in = '0; pv_in = 1'b0; found_in = 1'b0;
            inv_found_in = 1'b0; vic_ok_in = 1'b0; a_in = AGE_BITS'(1);
         end
         OP_LOOKUP: begin
            if (ev) begin
               if (e_hit && !found_ff) begin
                  found_in = 1'b1; tgt_in = ridx_ff; tgt_word_in = rd_word;
               end
               // Victim: first invalid entry, else oldest unpinned one.
               if (!e_v) begin
                  if (!inv_found_ff) begin
                     inv_found_in = 1'b1; vic_in = ridx_ff;
                  end
               end else if (e_pins == '0 && !inv_found_ff &&
                            (!vic_ok_ff || e_age < vic_age)) begin
                  vic_ok_in = 1'b1; vic_in = ridx_ff; vic_word_in = rd_word;
               end
            end
         end
         OP_FWB: begin
            if (ev && e_match && e_dirty) begin
               strobe_in = 1'b1; kind_in = KIND_WRITEBACK; oslot_in = 4'(ridx_ff);
               odev_in = dev_ff; olba_in = e_sec;
               wr_en = 1'b1;
               wr_data[MODE_LO +: 2] = wok_ff ? MODE_CLEAN : MODE_WBFAIL;
            end
         end
         OP_ICLR: begin
            if (ev && e_match) begin
               valid_in[ridx_ff] = 1'b0;
            end
         end
         OP_QUERY: begin
            if (ev) begin
               vcnt_in = vcnt_ff + CNT_W'(e_v);
               dcnt_in = dcnt_ff + CNT_W'(e_dirty);
               pcnt_in = pcnt_ff + CNT_W'(e_pinned);
            end
         end
         OP_RENUM: begin
            // Renumber valid entries in index order.
            if (ev && e_v) begin
               wr_en = 1'b1;
               wr_data[AGE_LO +: AGE_BITS] = a_ff;
               a_in = a_ff + AGE_BITS'(1);
            end
         end
         OP_NA_LOAD: next_age_in = a_ff;
         OP_INC_PIN: begin
            wr_en = 1'b1; wr_addr = tgt_ff; wr_data = tgt_word_ff;
            wr_data[PIN_LO +: PIN_BITS] = tgt_pins + PIN_BITS'(1);
         end
         OP_VIC_TGT: tgt_in = vic_ff;
         OP_EMIT_VWB: begin
            strobe_in = 1'b1; kind_in = KIND_WRITEBACK; oslot_in = 4'(tgt_ff);
            odev_in = vic_word_ff[DEV_LO +: DEV_W];
            olba_in = vic_word_ff[SEC_LO +: LBA_W];
            wr_en = 1'b1; wr_addr = tgt_ff; wr_data = vic_word_ff;
            wr_data[MODE_LO +: 2] = wok_ff ? MODE_CLEAN : MODE_WBFAIL;
         end
         OP_EMIT_FILL: begin
            strobe_in = 1'b1; kind_in = KIND_FILL; oslot_in = 4'(tgt_ff);
            odev_in = dev_ff; olba_in = lba_ff;
            if (rok_ff) begin
               wr_en = 1'b1; wr_addr = tgt_ff; wr_data = fill_word;
               valid_in[tgt_ff] = 1'b1;
            end
         end
         OP_RD_TGT: rd_addr = tgt_ff;
         OP_WR_AGE: begin
            wr_en = 1'b1; wr_addr = tgt_ff;
            wr_data[AGE_LO +: AGE_BITS] = next_age_ff;
            next_age_in = next_age_ff + AGE_BITS'(1);
            slot_in = 4'(tgt_ff);
         end
         OP_RD_IDX: begin
            rd_addr = eidx_ext; tgt_in = eidx_ext;
         end
         OP_MARK: begin
            wr_en = 1'b1; wr_addr = tgt_ff;
            wr_data[MODE_LO +: 2] = MODE_DIRTY;
         end
         OP_REL: begin
            wr_en = 1'b1; wr_addr = tgt_ff;
            wr_data[PIN_LO +: PIN_BITS] = e_pins - PIN_BITS'(1);
         end
         OP_EMIT_DFL: begin
            strobe_in = 1'b1; kind_in = KIND_DEV_FLUSH; odev_in = dev_ff;
         end
         OP_CLEAR: begin
            valid_in = '0; next_age_in = AGE_BITS'(1);
            prog_in = PH_IDLE; err_in = ST_OK;
         end
         OP_EMIT_ST: begin
            strobe_in = 1'b1; kind_in = KIND_STATUS; ost_in = st_ff;
            oslot_in = slot_ff; ov_in = 5'(vcnt_ff); od_in = 5'(dcnt_ff);
            op_in = 5'(pcnt_ff); oph_in = prog_ff; oerr_in = err_out;
            olast_in = 1'b1; err_in = err_out;
         end
         default: begin
         end
      endcase

      if (cmd.set_st) begin
         st_in = cmd.st;
      end
      if (cmd.set_prog) begin
         prog_in = cmd.prog;
      end
      if (cmd.clr_err) begin
         err_in = ST_OK;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; next_age_ff <= AGE_BITS'(1); prog_ff <= PH_IDLE;
         err_ff <= ST_OK; pv_ff <= 1'b0; strobe_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; next_age_ff <= next_age_in; prog_ff <= prog_in;
         err_ff <= err_in; pv_ff <= pv_in; strobe_ff <= strobe_in;
      end
      cmd_ff <= cmd_in; dev_ff <= dev_in; lba_ff <= lba_in; eidx_ff <= eidx_in;
      dstat_ff <= dstat_in; sect_ff <= sect_in;
      wok_ff <= wok_in; rok_ff <= rok_in; fok_ff <= fok_in;
      addr_ff <= addr_in; ridx_ff <= ridx_in; tgt_ff <= tgt_in;
      tgt_word_ff <= tgt_word_in; found_ff <= found_in;
      inv_found_ff <= inv_found_in; vic_ok_ff <= vic_ok_in; vic_ff <= vic_in;
      vic_word_ff <= vic_word_in; a_ff <= a_in; st_ff <= st_in; slot_ff <= slot_in;
      vcnt_ff <= vcnt_in; dcnt_ff <= dcnt_in; pcnt_ff <= pcnt_in;
      kind_ff <= kind_in; ost_ff <= ost_in; oslot_ff <= oslot_in; odev_ff <= odev_in;
      olba_ff <= olba_in; ov_ff <= ov_in; od_ff <= od_in; op_ff <= op_in;
      oph_ff <= oph_in; oerr_ff <= oerr_in; olast_ff <= olast_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_status         = ost_ff;
   assign rsp_slot           = oslot_ff;
   assign rsp_req_device     = odev_ff;
   assign rsp_req_lba        = olba_ff;
   assign rsp_valid_count    = ov_ff;
   assign rsp_dirty_count    = od_ff;
   assign rsp_pinned_count   = op_ff;
   assign rsp_flush_phase    = oph_ff;
   assign rsp_recorded_error = oerr_ff;
   assign rsp_last           = olast_ff;

   // Only the status word closes a command.
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && olast_ff |-> kind_ff == KIND_STATUS)
      else $error("last word is not a status word");

   // A request word never carries the closing mark.
   a_req_not_last: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && kind_ff != KIND_STATUS |-> !olast_ff)
      else $error("request word marked last");

   // A freshly loaded command starts with a clean status.
   a_load_clears_st: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |=> st_ff == ST_OK)
      else $error("status not cleared on load");

endmodule
`default_nettype wire

/* hw/rtl/plbc_ctl.sv */
// Controller: sequences each command through the datapath operations.
`timescale 1ns / 1ps
`default_nettype none
module plbc_ctl import plbc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire dp_sts_type  sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_A_INIT, S_A_LOOK, S_A_HIT, S_A_MISS, S_A_WB, S_A_FILL,
      S_T_CHK, S_R_INIT, S_R_SCAN, S_R_END, S_T_RD, S_T_WR,
      S_M_RD, S_M_EV,
      S_F_INIT, S_F_CHK, S_F_INIT2, S_F_WB, S_F_DEV,
      S_I_INIT, S_I_CHK, S_I_INIT2, S_I_CLR,
      S_Q_INIT, S_Q_SCAN, S_CLR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and the operation for this cycle.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.set_st   = 1'b0;
      cmd.st       = ST_OK;
      cmd.set_prog = 1'b0;
      cmd.prog     = PH_IDLE;
      cmd.clr_err  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               cmd.op = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.cmd)
               CMD_ACQUIRE:    state_in = S_A_INIT;
               CMD_MARK_DIRTY: state_in = S_M_RD;
               CMD_RELEASE:    state_in = S_M_RD;
               CMD_FLUSH:      state_in = S_F_INIT;
               CMD_INVALIDATE: state_in = S_I_INIT;
               CMD_QUERY:      state_in = S_Q_INIT;
               CMD_CLEAR:      state_in = S_CLR;
               default:        state_in = S_DONE;
            endcase
         end
         // Acquire: look up the tag while choosing a victim.
         S_A_INIT: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_A_LOOK;
         end
         S_A_LOOK: begin
            cmd.op = OP_LOOKUP;
            if (sts.stop) begin
               state_in = S_A_HIT;
            end else if (sts.last) begin
               state_in = S_A_MISS;
            end
         end
         S_A_HIT: begin
            if (sts.tgt_pins_max) begin
               cmd.set_st = 1'b1; cmd.st = ST_PIN_OVERFLOW;
               state_in = S_DONE;
            end else begin
               cmd.op = OP_INC_PIN;
               state_in = S_T_CHK;
            end
         end
         S_A_MISS: begin
            cmd.op = OP_VIC_TGT;
            cmd.set_st = 1'b1;
            state_in = S_DONE;
            if (!sts.vic_any) begin
               cmd.st = ST_ALL_PINNED;
            end else if (sts.bad_size) begin
               cmd.st = ST_BAD_SIZE;
            end else if (sts.oor) begin
               cmd.st = ST_OUT_OF_RANGE;
            end else if (sts.not_ready) begin
               cmd.st = ST_READ_FAILED;
            end else begin
               cmd.set_st = 1'b0;
               state_in = sts.vic_dirty ? S_A_WB : S_A_FILL;
            end
         end
         S_A_WB: begin
            cmd.op = OP_EMIT_VWB;
            if (sts.wok) begin
               state_in = S_A_FILL;
            end else begin
               cmd.set_st = 1'b1; cmd.st = ST_WB_FAILED;
               state_in = S_DONE;
            end
         end
         S_A_FILL: begin
            cmd.op = OP_EMIT_FILL;
            if (sts.rok) begin
               state_in = S_T_CHK;
            end else begin
               cmd.set_st = 1'b1; cmd.st = ST_READ_FAILED;
               state_in = S_DONE;
            end
         end
         // Touch: renumber ages on wrap, then stamp the target.
         S_T_CHK:  state_in = sts.age_wrap ? S_R_INIT : S_T_RD;
         S_R_INIT: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_R_SCAN;
         end
         S_R_SCAN: begin
            cmd.op = OP_RENUM;
            if (sts.last) begin
               state_in = S_R_END;
            end
         end
         S_R_END: begin
            cmd.op = OP_NA_LOAD;
            state_in = S_T_RD;
         end
         S_T_RD: begin
            cmd.op = OP_RD_TGT;
            state_in = S_T_WR;
         end
         S_T_WR: begin
            cmd.op = OP_WR_AGE;
            state_in = S_DONE;
         end
         // Mark dirty and release.
         S_M_RD: begin
            cmd.op = OP_RD_IDX;
            state_in = S_M_EV;
         end
         S_M_EV: begin
            state_in = S_DONE;
            if (!sts.idx_ok) begin
               cmd.set_st = 1'b1; cmd.st = ST_MISMATCH;
            end else if (sts.rd_pins_zero) begin
               cmd.set_st = 1'b1; cmd.st = ST_PIN_UNDER;
            end else begin
               cmd.op = (sts.cmd == CMD_MARK_DIRTY) ? OP_MARK : OP_REL;
            end
         end
         // Flush a device.
         S_F_INIT: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            cmd.op = OP_FCHK;
            if (sts.stop) begin
               cmd.set_st = 1'b1; cmd.st = ST_PINNED_DIRTY;
               cmd.set_prog = 1'b1; cmd.prog = PH_FAILED;
               state_in = S_DONE;
            end else if (sts.last) begin
               state_in = S_F_INIT2;
            end
         end
         S_F_INIT2: begin
            cmd.op = OP_SCAN_INIT;
            cmd.set_prog = 1'b1; cmd.prog = PH_WRITING;
            state_in = S_F_WB;
         end
         S_F_WB: begin
            cmd.op = OP_FWB;
            if (sts.stop) begin
               cmd.set_st = 1'b1; cmd.st = ST_WB_FAILED;
               cmd.set_prog = 1'b1; cmd.prog = PH_FAILED;
               state_in = S_DONE;
            end else if (sts.last) begin
               state_in = S_F_DEV;
            end
         end
         S_F_DEV: begin
            cmd.op = OP_EMIT_DFL;
            cmd.set_prog = 1'b1;
            if (sts.fok) begin
               cmd.prog = PH_COMPLETE; cmd.clr_err = 1'b1;
            end else begin
               cmd.prog = PH_FAILED;
               cmd.set_st = 1'b1; cmd.st = ST_DEV_FLUSH;
            end
            state_in = S_DONE;
         end
         // Invalidate a device.
         S_I_INIT: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_I_CHK;
         end
         S_I_CHK: begin
            cmd.op = OP_ICHK;
            if (sts.stop) begin
               cmd.set_st = 1'b1;
               cmd.st = sts.e_pinned ? ST_ALL_PINNED : ST_WB_FAILED;
               state_in = S_DONE;
            end else if (sts.last) begin
               state_in = S_I_INIT2;
            end
         end
         S_I_INIT2: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_I_CLR;
         end
         S_I_CLR: begin
            cmd.op = OP_ICLR;
            if (sts.last) begin
               state_in = S_DONE;
            end
         end
         // Query.
         S_Q_INIT: begin
            cmd.op = OP_SCAN_INIT;
            state_in = S_Q_SCAN;
         end
         S_Q_SCAN: begin
            cmd.op = OP_QUERY;
            if (sts.last) begin
               state_in = S_DONE;
            end
         end
         S_CLR: begin
            cmd.op = OP_CLEAR;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.op = OP_EMIT_ST;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= state_in != S_IDLE;
      end
   end

   assign busy = busy_ff;

   // An accepted command makes the block busy at once.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff)
      else $error("command accepted but block not busy");

   // Busy tracks exactly whether the sequencer is away from idle.
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy out of step with state");

   // The closing status always returns the sequencer to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> state_ff == S_IDLE && !busy_ff)
      else $error("no return to idle after status");

endmodule
`default_nettype wire

/* hw/rtl/pinned_lru_block_cache_controller.sv */
// Top level of the pinned LRU block cache tag and state controller.
//
//   Channel   Handshake             Words
//   req_*     start, busy           one command, taken when start & !busy
//   rsp_*     rsp_strobe            requests then one status word (rsp_last)
//
// Commands that walk the entries (query, invalidate, flush, acquire) scan the store,
// one store read per cycle; an acquire also renumbers the ages when the age counter wraps.
// Reset empties all entries at once through the valid flip-flops.
// Result words are shown for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module pinned_lru_block_cache_controller import plbc_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int PIN_BITS = PIN_BITS_DEF,
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_cmd,
   input  wire logic [DEV_W-1:0]  req_device_id,
   input  wire logic [LBA_W-1:0]  req_lba,
   input  wire logic [3:0]        req_entry_index,
   input  wire logic [2:0]        req_device_status,
   input  wire logic [SECT_W-1:0] req_device_sectors,
   input  wire logic              req_write_ok,
   input  wire logic              req_read_ok,
   input  wire logic              req_flush_ok,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_kind,
   output logic [3:0]             rsp_status,
   output logic [3:0]             rsp_slot,
   output logic [DEV_W-1:0]       rsp_req_device,
   output logic [LBA_W-1:0]       rsp_req_lba,
   output logic [4:0]             rsp_valid_count,
   output logic [4:0]             rsp_dirty_count,
   output logic [4:0]             rsp_pinned_count,
   output logic [2:0]             rsp_flush_phase,
   output logic [3:0]             rsp_recorded_error,
   output logic                   rsp_last
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // Sequencer.
   plbc_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Entry store and result path.
   plbc_dp #(
      .ENTRIES  (ENTRIES),
      .PIN_BITS (PIN_BITS),
      .AGE_BITS (AGE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_cmd            (req_cmd),
      .req_device_id      (req_device_id),
      .req_lba            (req_lba),
      .req_entry_index    (req_entry_index),
      .req_device_status  (req_device_status),
      .req_device_sectors (req_device_sectors),
      .req_write_ok       (req_write_ok),
      .req_read_ok        (req_read_ok),
      .req_flush_ok       (req_flush_ok),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_req_device     (rsp_req_device),
      .rsp_req_lba        (rsp_req_lba),
      .rsp_valid_count    (rsp_valid_count),
      .rsp_dirty_count    (rsp_dirty_count),
      .rsp_pinned_count   (rsp_pinned_count),
      .rsp_flush_phase    (rsp_flush_phase),
      .rsp_recorded_error (rsp_recorded_error),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the pinned LRU block cache tag and state controller.
`timescale 1ns / 1ps
module tb;
   import plbc_pkg::*;

   localparam int NENT = 16;
   localparam logic [1:0] MODE_INVALID = 2'd0;
   localparam logic [7:0] PIN_MAX = 8'hff;
   localparam logic [15:0] AGE_MAX = 16'hffff;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;
   localparam logic [2:0] DS_READY = 3'd0;
   localparam logic [2:0] DS_BUSY = 3'd2;
   localparam logic [2:0] DS_ODD = 3'd7;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [DEV_W-1:0]  dev;
      logic [LBA_W-1:0]  lba;
      logic [3:0]        idx;
      logic [2:0]        dstat;
      logic [SECT_W-1:0] sectors;
      logic              wok;
      logic              rok;
      logic              fok;
   } cmd_word_t;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       status;
      logic [3:0]       slot;
      logic [DEV_W-1:0] dev;
      logic [LBA_W-1:0] lba;
      logic [4:0]       nvalid;
      logic [4:0]       ndirty;
      logic [4:0]       npinned;
      logic [2:0]       phase;
      logic [3:0]       err;
      logic             last;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cmd_word_t cur = '0;
   logic rsp_strobe, rsp_last;
   logic [1:0] rsp_kind;
   logic [3:0] rsp_status, rsp_slot, rsp_recorded_error;
   logic [DEV_W-1:0] rsp_req_device;
   logic [LBA_W-1:0] rsp_req_lba;
   logic [4:0] rsp_valid_count, rsp_dirty_count, rsp_pinned_count;
   logic [2:0] rsp_flush_phase;

   cmd_word_t pending_cmds[$];
   rsp_word_t expected_words[$];
   int mismatches = 0;
   int gap = 0;

   // Shadow copy of the cache tag and state store.
   logic [1:0]       sh_mode[NENT];
   logic [DEV_W-1:0] sh_dev[NENT];
   logic [LBA_W-1:0] sh_sect[NENT];
   logic [7:0]       sh_pins[NENT];
   logic [15:0]      sh_age[NENT];
   logic [15:0]      sh_next_age;
   logic [2:0]       sh_phase;
   logic [3:0]       sh_err;

   pinned_lru_block_cache_controller i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(cur.cmd), .req_device_id(cur.dev), .req_lba(cur.lba),
      .req_entry_index(cur.idx), .req_device_status(cur.dstat),
      .req_device_sectors(cur.sectors), .req_write_ok(cur.wok),
      .req_read_ok(cur.rok), .req_flush_ok(cur.fok),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_req_device(rsp_req_device), .rsp_req_lba(rsp_req_lba),
      .rsp_valid_count(rsp_valid_count), .rsp_dirty_count(rsp_dirty_count),
      .rsp_pinned_count(rsp_pinned_count), .rsp_flush_phase(rsp_flush_phase),
      .rsp_recorded_error(rsp_recorded_error), .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_cache();
      for (int i = 0; i < NENT; i++) begin
         sh_mode[i] = MODE_INVALID;
         sh_dev[i] = '0;
         sh_sect[i] = '0;
         sh_pins[i] = '0;
         sh_age[i] = '0;
      end
      sh_next_age = 16'd1;
      sh_phase = PH_IDLE;
      sh_err = ST_OK;
   endfunction

   function automatic bit holds_dirty(int i);
      return sh_mode[i] == MODE_DIRTY || sh_mode[i] == MODE_WBFAIL;
   endfunction

   // Queue one expected word; status words carry phase and error after the command.
   function automatic void expect_word(logic [1:0] k, logic [3:0] st, logic [3:0] sl,
                                       logic [DEV_W-1:0] dv, logic [LBA_W-1:0] lb,
                                       logic [4:0] v, logic [4:0] d, logic [4:0] p,
                                       bit stat);
      rsp_word_t w;
      w.kind = k; w.status = st; w.slot = sl; w.dev = dv; w.lba = lb;
      w.nvalid = v; w.ndirty = d; w.npinned = p;
      w.phase = stat ? sh_phase : 3'd0;
      w.err = stat ? sh_err : 4'd0;
      w.last = stat;
      expected_words.push_back(w);
   endfunction

   // LRU touch, renumbering valid entries in index order when the counter is full.
   function automatic void lru_touch(int idx);
      logic [15:0] a;
      if (sh_next_age == AGE_MAX) begin
         a = 16'd1;
         for (int i = 0; i < NENT; i++) begin
            if (sh_mode[i] != MODE_INVALID) begin
               sh_age[i] = a;
               a++;
            end
         end
         sh_next_age = a;
      end
      sh_age[idx] = sh_next_age;
      sh_next_age = sh_next_age + 16'd1;
   endfunction

   function automatic logic [3:0] acquire_sector(cmd_word_t c, output logic [3:0] slot);
      int vic;
      vic = -1;
      slot = '0;
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] != MODE_INVALID && sh_dev[i] == c.dev && sh_sect[i] == c.lba) begin
            if (sh_pins[i] == PIN_MAX) return ST_PIN_OVERFLOW;
            sh_pins[i]++;
            lru_touch(i);
            slot = i[3:0];
            return ST_OK;
         end
      end
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] == MODE_INVALID) begin
            vic = i;
            break;
         end
         if (sh_pins[i] == 0 && (vic < 0 || sh_age[i] < sh_age[vic])) vic = i;
      end
      if (vic < 0) return ST_ALL_PINNED;
      if (c.dstat == DS_WRONG_SIZE) return ST_BAD_SIZE;
      if ({1'b0, c.lba} >= c.sectors) return ST_OUT_OF_RANGE;
      if (c.dstat > DS_READ_ONLY) return ST_READ_FAILED;
      // A dirty victim is written back before the fill.
      if (holds_dirty(vic)) begin
         expect_word(KIND_WRITEBACK, ST_OK, vic[3:0], sh_dev[vic], sh_sect[vic], 0, 0, 0, 0);
         if (!c.wok) begin
            sh_mode[vic] = MODE_WBFAIL;
            return ST_WB_FAILED;
         end
         sh_mode[vic] = MODE_CLEAN;
      end
      expect_word(KIND_FILL, ST_OK, vic[3:0], c.dev, c.lba, 0, 0, 0, 0);
      if (!c.rok) return ST_READ_FAILED;
      sh_dev[vic] = c.dev;
      sh_sect[vic] = c.lba;
      sh_pins[vic] = 8'd1;
      sh_mode[vic] = MODE_CLEAN;
      lru_touch(vic);
      slot = vic[3:0];
      return ST_OK;
   endfunction

   function automatic logic [3:0] flush_device(cmd_word_t c);
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] != MODE_INVALID && sh_dev[i] == c.dev && sh_pins[i] != 0
             && holds_dirty(i)) begin
            sh_phase = PH_FAILED;
            return ST_PINNED_DIRTY;
         end
      end
      sh_phase = PH_WRITING;
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] == MODE_INVALID || sh_dev[i] != c.dev || !holds_dirty(i)) continue;
         expect_word(KIND_WRITEBACK, ST_OK, i[3:0], c.dev, sh_sect[i], 0, 0, 0, 0);
         if (!c.wok) begin
            sh_mode[i] = MODE_WBFAIL;
            sh_phase = PH_FAILED;
            return ST_WB_FAILED;
         end
         sh_mode[i] = MODE_CLEAN;
      end
      sh_phase = PH_FLUSHING;
      expect_word(KIND_DEV_FLUSH, ST_OK, 4'd0, c.dev, '0, 0, 0, 0, 0);
      if (!c.fok) begin
         sh_phase = PH_FAILED;
         return ST_DEV_FLUSH;
      end
      sh_phase = PH_COMPLETE;
      sh_err = ST_OK;
      return ST_OK;
   endfunction

   function automatic logic [3:0] invalidate_device(cmd_word_t c);
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] != MODE_INVALID && sh_dev[i] == c.dev
             && (sh_pins[i] != 0 || holds_dirty(i)))
            return (sh_pins[i] != 0) ? ST_ALL_PINNED : ST_WB_FAILED;
      end
      for (int i = 0; i < NENT; i++) begin
         if (sh_mode[i] != MODE_INVALID && sh_dev[i] == c.dev) begin
            sh_mode[i] = MODE_INVALID;
            sh_dev[i] = '0;
            sh_sect[i] = '0;
            sh_pins[i] = '0;
            sh_age[i] = '0;
         end
      end
      return ST_OK;
   endfunction

   // Work out every word one accepted command produces.
   function automatic void predict_command(cmd_word_t c);
      logic [3:0] st, slot;
      logic [4:0] v, d, p;
      st = ST_OK; slot = '0; v = '0; d = '0; p = '0;
      case (c.cmd)
         CMD_ACQUIRE: st = acquire_sector(c, slot);
         CMD_MARK_DIRTY, CMD_RELEASE: begin
            slot = c.idx;
            if (sh_mode[c.idx] == MODE_INVALID) st = ST_MISMATCH;
            else if (sh_pins[c.idx] == 0) st = ST_PIN_UNDER;
            else if (c.cmd == CMD_MARK_DIRTY) sh_mode[c.idx] = MODE_DIRTY;
            else sh_pins[c.idx]--;
         end
         CMD_FLUSH: st = flush_device(c);
         CMD_INVALIDATE: st = invalidate_device(c);
         CMD_QUERY: begin
            for (int i = 0; i < NENT; i++) begin
               if (sh_mode[i] != MODE_INVALID) v++;
               if (holds_dirty(i)) d++;
               if (sh_pins[i] != 0) p++;
            end
         end
         CMD_CLEAR: clear_cache();
         default: ;
      endcase
      if (st != ST_OK) sh_err = st;
      expect_word(KIND_STATUS, st, slot, '0, '0, v, d, p, 1);
   endfunction

   function automatic cmd_word_t mk(logic [2:0] cmd, logic [3:0] dev, logic [47:0] lba,
                                    logic [3:0] idx);
      cmd_word_t c;
      c.cmd = cmd; c.dev = dev; c.lba = lba; c.idx = idx;
      c.dstat = DS_READY; c.sectors = {1'b1, 48'd0};
      c.wok = 1'b1; c.rok = 1'b1; c.fok = 1'b1;
      return c;
   endfunction

   function automatic cmd_word_t random_cmd();
      cmd_word_t c;
      int r;
      r = $urandom_range(0, 99);
      c.cmd = r < 40 ? CMD_ACQUIRE : r < 52 ? CMD_MARK_DIRTY : r < 67 ? CMD_RELEASE :
              r < 76 ? CMD_FLUSH : r < 83 ? CMD_INVALIDATE : r < 94 ? CMD_QUERY :
              r < 97 ? CMD_CLEAR : CMD_UNKNOWN;
      // Small address pool so hits, evictions and repeated pins happen often.
      c.dev = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      c.lba = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                          : 48'($urandom_range(0, 23));
      c.idx = 4'($urandom);
      c.dstat = ($urandom_range(0, 4) == 0) ? 3'($urandom) : DS_READY;
      c.sectors = ($urandom_range(0, 7) == 0) ? {17'($urandom), 32'($urandom)}
                                              : {1'b1, 48'd0};
      c.wok = $urandom_range(0, 9) != 0;
      c.rok = $urandom_range(0, 9) != 0;
      c.fok = $urandom_range(0, 7) != 0;
      return c;
   endfunction

   // Driver: presents the next pending word and holds it until it is taken.
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && !busy) begin
            predict_command(cur);
            go = 1'b0;
         end
         if (!go) begin
            if (gap > 0) begin
               gap--;
            end else if (pending_cmds.size() > 0) begin
               if (pending_cmds.size() > 40 && $urandom_range(0, 3) == 0) begin
                  gap = $urandom_range(1, 13);
               end else begin
                  cur <= pending_cmds.pop_front();
                  go = 1'b1;
               end
            end
         end
         start <= go;
      end
   end

   // Monitor: every strobed word must match the oldest expectation.
   always @(posedge clock) begin
      rsp_word_t act, exp_w;
      if (!reset && rsp_strobe) begin
         act = '{rsp_kind, rsp_status, rsp_slot, rsp_req_device, rsp_req_lba,
                 rsp_valid_count, rsp_dirty_count, rsp_pinned_count,
                 rsp_flush_phase, rsp_recorded_error, rsp_last};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", act);
         end else begin
            exp_w = expected_words.pop_front();
            if (act !== exp_w) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_w, act);
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      cmd_word_t c;
      clear_cache();
      // Directed corner cases.
      pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 4'd15));
      pending_cmds.push_back(mk(CMD_ACQUIRE, 0, 0, 0));
      c = mk(CMD_ACQUIRE, 4'd15, 48'hffff_ffff_ffff, 0);
      pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 5, 0); c.dstat = DS_WRONG_SIZE; pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 5, 0); c.sectors = 49'd5; pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 5, 0); c.dstat = DS_BUSY; pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 5, 0); c.dstat = DS_ODD; pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 5, 0); c.rok = 1'b0; pending_cmds.push_back(c);
      c = mk(CMD_ACQUIRE, 1, 6, 0); c.dstat = DS_READ_ONLY; pending_cmds.push_back(c);
      pending_cmds.push_back(mk(CMD_MARK_DIRTY, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_FLUSH, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_MARK_DIRTY, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_INVALIDATE, 0, 0, 0));
      c = mk(CMD_FLUSH, 0, 0, 0); c.wok = 1'b0; pending_cmds.push_back(c);
      c = mk(CMD_FLUSH, 0, 0, 0); c.fok = 1'b0; pending_cmds.push_back(c);
      pending_cmds.push_back(mk(CMD_FLUSH, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_INVALIDATE, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_INVALIDATE, 4'd15, 0, 0));
      pending_cmds.push_back(mk(CMD_UNKNOWN, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0));
      // Pin every entry, then ask for one more sector.
      pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0));
      for (int i = 0; i < 17; i++) pending_cmds.push_back(mk(CMD_ACQUIRE, 3, 48'(i), 0));
      for (int i = 0; i < 16; i++) begin
         pending_cmds.push_back(mk(CMD_MARK_DIRTY, 0, 0, 4'(i)));
         pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 4'(i)));
      end
      for (int i = 0; i < 136; i++) pending_cmds.push_back(random_cmd());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !start);
      wait (expected_words.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("pinned_lru_block_cache_controller regression: pass");
      end else begin
         $display("pinned_lru_block_cache_controller regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("pinned_lru_block_cache_controller regression: fail");
      $finish;
   end
endmodule

/* files.f */
hw/rtl/plbc_pkg.sv
hw/rtl/plbc_ram.sv
hw/rtl/plbc_dp.sv
hw/rtl/plbc_ctl.sv
hw/rtl/pinned_lru_block_cache_controller.sv
tb/tb.sv
